### rtl/rbmi_pkg.sv
// ----------------------------------------------------------------------------
// rbmi_pkg
// Shared types, constants and arithmetic helpers for the 2D motion integrator.
// ----------------------------------------------------------------------------
package rbmi_pkg;

   localparam int DIV_STAGES  = 48;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   localparam logic [1:0] CSR_GRAVITY_X = 2'd0;
   localparam logic [1:0] CSR_GRAVITY_Y = 2'd1;
   localparam logic [1:0] CSR_DRAG      = 2'd2;
   localparam logic [1:0] CSR_REST      = 2'd3;

   localparam logic [30:0] REST_RESET = 31'd655;

   typedef struct packed {
      logic        [15:0] body_tag;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] force_x;
      logic signed [31:0] force_y;
      logic        [30:0] mass;
      logic        [30:0] step_time;
   } req_type;

   typedef struct packed {
      logic        [15:0] tag_out;
      logic signed [31:0] new_pos_x;
      logic signed [31:0] new_pos_y;
      logic signed [31:0] new_vel_x;
      logic signed [31:0] new_vel_y;
      logic               moved;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] gravity_x;
      logic signed [31:0] gravity_y;
      logic        [30:0] drag_coefficient;
      logic        [30:0] rest_speed_sq;
   } cfg_type;

   typedef struct packed {
      logic        [15:0] tag;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic signed [31:0] fx;
      logic signed [31:0] fy;
      logic        [30:0] mass;
      logic        [30:0] dt;
      logic               moving;
   } mid_type;

   typedef struct packed {
      logic        [15:0] tag;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic        [30:0] dt;
      logic               moving;
   } carry_type;

   typedef struct packed {
      logic [31:0] r_x;
      logic [31:0] r_y;
      logic [47:0] q_x;
      logic [47:0] q_y;
      logic [47:0] n_x;
      logic [47:0] n_y;
      logic        neg_x;
      logic        neg_y;
      logic        nz_x;
      logic        nz_y;
      logic [30:0] dvsr;
      logic        mzero;
   } div_type;

   function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
      logic signed [31:0] res;
      if (x > 50'sd2147483647) begin
         res = 32'sh7FFFFFFF;
      end else if (x < -50'sd2147483648) begin
         res = 32'sh80000000;
      end else begin
         res = x[31:0];
      end
      return res;
   endfunction

   function automatic div_type div_step(input div_type d);
      div_type     o;
      logic [31:0] t_x;
      logic [31:0] t_y;
      o   = d;
      t_x = {d.r_x[30:0], d.n_x[47]};
      t_y = {d.r_y[30:0], d.n_y[47]};
      o.n_x = {d.n_x[46:0], 1'b0};
      o.n_y = {d.n_y[46:0], 1'b0};
      if (t_x >= {1'b0, d.dvsr}) begin
         o.r_x = t_x - {1'b0, d.dvsr};
         o.q_x = {d.q_x[46:0], 1'b1};
      end else begin
         o.r_x = t_x;
         o.q_x = {d.q_x[46:0], 1'b0};
      end
      if (t_y >= {1'b0, d.dvsr}) begin
         o.r_y = t_y - {1'b0, d.dvsr};
         o.q_y = {d.q_y[46:0], 1'b1};
      end else begin
         o.r_y = t_y;
         o.q_y = {d.q_y[46:0], 1'b0};
      end
      return o;
   endfunction

endpackage

### rtl/rbmi_front.sv
// ----------------------------------------------------------------------------
// rbmi_front
// Takes bodies in, sums force + gravity - drag and decides rest/motion.
// ----------------------------------------------------------------------------
module rbmi_front import rbmi_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    in_push,
   input  req_type in_data,
   output logic    in_full,
   output logic    out_push,
   output mid_type out_data,
   input  logic    out_full
);

   logic               s0_vld_ff;
   req_type            s0_ff;
   logic               s1_vld_ff;
   req_type            s1_ff;
   logic signed [63:0] pdx_ff;
   logic signed [63:0] pdy_ff;
   logic signed [63:0] sqx_ff;
   logic signed [63:0] sqy_ff;
   logic signed [63:0] pdx_in;
   logic signed [63:0] pdy_in;
   logic signed [63:0] sqx_in;
   logic signed [63:0] sqy_in;
   logic               adv;
   logic signed [49:0] fsum_x;
   logic signed [49:0] fsum_y;
   logic signed [31:0] f_x;
   logic signed [31:0] f_y;
   logic        [64:0] sq_sum;

   assign adv     = !(s1_vld_ff && out_full);
   assign in_full = !adv;

   always_comb begin
      pdx_in = s0_ff.vel_x * $signed({1'b0, cfg.drag_coefficient});
      pdy_in = s0_ff.vel_y * $signed({1'b0, cfg.drag_coefficient});
      sqx_in = s0_ff.vel_x * s0_ff.vel_x;
      sqy_in = s0_ff.vel_y * s0_ff.vel_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s0_vld_ff <= in_push;
         s1_vld_ff <= s0_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_ff  <= in_data;
         s1_ff  <= s0_ff;
         pdx_ff <= pdx_in;
         pdy_ff <= pdy_in;
         sqx_ff <= sqx_in;
         sqy_ff <= sqy_in;
      end
   end

   always_comb begin
      fsum_x = 50'(s1_ff.force_x) + 50'(cfg.gravity_x) - 50'($signed(pdx_ff[63:16]));
      fsum_y = 50'(s1_ff.force_y) + 50'(cfg.gravity_y) - 50'($signed(pdy_ff[63:16]));
      f_x    = sat32(fsum_x);
      f_y    = sat32(fsum_y);
      sq_sum = {1'b0, sqx_ff} + {1'b0, sqy_ff};
      out_data.tag    = s1_ff.body_tag;
      out_data.px     = s1_ff.pos_x;
      out_data.py     = s1_ff.pos_y;
      out_data.vx     = s1_ff.vel_x;
      out_data.vy     = s1_ff.vel_y;
      out_data.fx     = f_x;
      out_data.fy     = f_y;
      out_data.mass   = s1_ff.mass;
      out_data.dt     = s1_ff.step_time;
      out_data.moving = (sq_sum[64:16] > {18'd0, cfg.rest_speed_sq})
                        || (f_x != 32'sd0) || (f_y != 32'sd0);
   end

   assign out_push = s1_vld_ff && !out_full;

endmodule

### rtl/rbmi_queue.sv
// ----------------------------------------------------------------------------
// rbmi_queue
// Short queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module rbmi_queue import rbmi_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  mid_type push_data,
   output logic    full,
   input  logic    pop,
   output mid_type pop_data,
   output logic    empty
);

   mid_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] cnt_ff;
   logic              do_push;
   logic              do_pop;

   assign full     = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         cnt_ff <= cnt_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

### rtl/rbmi_back.sv
// ----------------------------------------------------------------------------
// rbmi_back
// Divides force by mass in a bit-per-stage pipeline, integrates the step and
// queues the results.
// ----------------------------------------------------------------------------
module rbmi_back import rbmi_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_empty,
   input  mid_type in_data,
   output logic    in_pop,
   output logic    out_empty,
   output rsp_type out_data,
   input  logic    out_pop
);

   div_type            dv_ff  [DIV_STAGES+1];
   carry_type          cr_ff  [DIV_STAGES+1];
   logic [DIV_STAGES:0] vld_ff;
   div_type            dv_in;
   carry_type          cr_in;
   logic [31:0]        mag_x;
   logic [31:0]        mag_y;

   logic               ac_vld_ff;
   carry_type          ac_cr_ff;
   logic signed [31:0] ax_ff;
   logic signed [31:0] ay_ff;
   logic signed [31:0] ax_in;
   logic signed [31:0] ay_in;

   logic               m1_vld_ff;
   carry_type          m1_cr_ff;
   logic signed [63:0] adt_x_ff;
   logic signed [63:0] adt_y_ff;
   logic signed [63:0] vdt_x_ff;
   logic signed [63:0] vdt_y_ff;

   logic               m2_vld_ff;
   carry_type          m2_cr_ff;
   logic signed [63:0] hp_x_ff;
   logic signed [63:0] hp_y_ff;
   logic signed [47:0] vd_x_ff;
   logic signed [47:0] vd_y_ff;
   logic signed [31:0] nv_x_ff;
   logic signed [31:0] nv_y_ff;
   logic signed [31:0] dv_x;
   logic signed [31:0] dv_y;

   rsp_type            res;
   logic signed [31:0] np_x;
   logic signed [31:0] np_y;

   rsp_type           oq_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] oq_wr_ff;
   logic [QPTR_W-1:0] oq_rd_ff;
   logic [QCNT_W-1:0] oq_cnt_ff;
   logic              oq_full;
   logic              oq_push;
   logic              oq_pop;
   logic              adv;

   assign oq_full = (oq_cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign adv     = !(m2_vld_ff && oq_full);
   assign in_pop  = adv && !in_empty;

   always_comb begin
      mag_x = in_data.fx[31] ? 32'(-in_data.fx) : 32'(in_data.fx);
      mag_y = in_data.fy[31] ? 32'(-in_data.fy) : 32'(in_data.fy);
      dv_in.r_x   = '0;
      dv_in.r_y   = '0;
      dv_in.q_x   = '0;
      dv_in.q_y   = '0;
      dv_in.n_x   = {mag_x, 16'd0};
      dv_in.n_y   = {mag_y, 16'd0};
      dv_in.neg_x = in_data.fx[31];
      dv_in.neg_y = in_data.fy[31];
      dv_in.nz_x  = (in_data.fx != 32'sd0);
      dv_in.nz_y  = (in_data.fy != 32'sd0);
      dv_in.dvsr  = in_data.mass;
      dv_in.mzero = (in_data.mass == 31'd0);
      cr_in.tag    = in_data.tag;
      cr_in.px     = in_data.px;
      cr_in.py     = in_data.py;
      cr_in.vx     = in_data.vx;
      cr_in.vy     = in_data.vy;
      cr_in.dt     = in_data.dt;
      cr_in.moving = in_data.moving;
   end

   always_comb begin
      div_type d;
      d = dv_ff[DIV_STAGES];
      if (d.mzero) begin
         ax_in = d.neg_x ? 32'sh80000000 : (d.nz_x ? 32'sh7FFFFFFF : 32'sd0);
         ay_in = d.neg_y ? 32'sh80000000 : (d.nz_y ? 32'sh7FFFFFFF : 32'sd0);
      end else begin
         ax_in = sat32(d.neg_x ? -$signed({2'b00, d.q_x}) : $signed({2'b00, d.q_x}));
         ay_in = sat32(d.neg_y ? -$signed({2'b00, d.q_y}) : $signed({2'b00, d.q_y}));
      end
   end

   always_comb begin
      dv_x = sat32(50'($signed(adt_x_ff[63:16])));
      dv_y = sat32(50'($signed(adt_y_ff[63:16])));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         ac_vld_ff <= 1'b0;
         m1_vld_ff <= 1'b0;
         m2_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff    <= {vld_ff[DIV_STAGES-1:0], !in_empty};
         ac_vld_ff <= vld_ff[DIV_STAGES];
         m1_vld_ff <= ac_vld_ff;
         m2_vld_ff <= m1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_ff[0] <= dv_in;
         cr_ff[0] <= cr_in;
         for (int k = 0; k < DIV_STAGES; k++) begin
            dv_ff[k+1] <= div_step(dv_ff[k]);
            cr_ff[k+1] <= cr_ff[k];
         end
         ac_cr_ff <= cr_ff[DIV_STAGES];
         ax_ff    <= ax_in;
         ay_ff    <= ay_in;
         m1_cr_ff <= ac_cr_ff;
         adt_x_ff <= ax_ff * $signed({1'b0, ac_cr_ff.dt});
         adt_y_ff <= ay_ff * $signed({1'b0, ac_cr_ff.dt});
         vdt_x_ff <= ac_cr_ff.vx * $signed({1'b0, ac_cr_ff.dt});
         vdt_y_ff <= ac_cr_ff.vy * $signed({1'b0, ac_cr_ff.dt});
         m2_cr_ff <= m1_cr_ff;
         hp_x_ff  <= dv_x * $signed({1'b0, m1_cr_ff.dt});
         hp_y_ff  <= dv_y * $signed({1'b0, m1_cr_ff.dt});
         vd_x_ff  <= $signed(vdt_x_ff[63:16]);
         vd_y_ff  <= $signed(vdt_y_ff[63:16]);
         nv_x_ff  <= sat32(50'(m1_cr_ff.vx) + 50'(dv_x));
         nv_y_ff  <= sat32(50'(m1_cr_ff.vy) + 50'(dv_y));
      end
   end

   always_comb begin
      np_x = sat32(50'(m2_cr_ff.px) + 50'($signed(hp_x_ff[63:17])) + 50'(vd_x_ff));
      np_y = sat32(50'(m2_cr_ff.py) + 50'($signed(hp_y_ff[63:17])) + 50'(vd_y_ff));
      res.tag_out = m2_cr_ff.tag;
      if (m2_cr_ff.moving) begin
         res.new_pos_x = np_x;
         res.new_pos_y = np_y;
         res.new_vel_x = nv_x_ff;
         res.new_vel_y = nv_y_ff;
      end else begin
         res.new_pos_x = m2_cr_ff.px;
         res.new_pos_y = m2_cr_ff.py;
         res.new_vel_x = '0;
         res.new_vel_y = '0;
      end
      res.moved = (res.new_pos_x != m2_cr_ff.px) || (res.new_pos_y != m2_cr_ff.py);
   end

   assign oq_push   = m2_vld_ff && !oq_full;
   assign out_empty = (oq_cnt_ff == '0);
   assign oq_pop    = out_pop && !out_empty;
   assign out_data  = oq_ff[oq_rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ff  <= '0;
         oq_rd_ff  <= '0;
         oq_cnt_ff <= '0;
      end else begin
         if (oq_push) oq_wr_ff <= oq_wr_ff + 1'b1;
         if (oq_pop)  oq_rd_ff <= oq_rd_ff + 1'b1;
         oq_cnt_ff <= oq_cnt_ff + QCNT_W'(oq_push) - QCNT_W'(oq_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (oq_push) oq_ff[oq_wr_ff] <= res;
   end

endmodule

### rtl/rigid_body_motion_integrator_2d_top.sv
// ----------------------------------------------------------------------------
// rigid_body_motion_integrator_2d_top
// Advances one 2D body per item by one time step in Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Write gravity, drag and rest threshold through csr_we/csr_index/csr_wdata
//   while no body is in flight. Push bodies with req_push while req_full is
//   low; pop results with rsp_pop while rsp_empty is low. One result per body,
//   in order.
// Timing:
//   One body per cycle sustained while req_full is low. A body passes 1 more
//   front stage, a queue stage, 49 stages of the bit-per-stage force/mass
//   divider and 3 multiply/integrate stages into the output queue.
// Reset:
//   Synchronous; empties both queues, drops bodies in flight and loads the
//   register defaults (rest threshold 655, others 0).
// Stall:
//   With rsp_pop low, 4 results wait in the output queue, then the back
//   pipeline holds, the middle queue fills and req_full rises.
// ----------------------------------------------------------------------------
module rigid_body_motion_integrator_2d_top import rbmi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_push,
   input  req_type     req_data,
   output logic        req_full,
   output logic        rsp_empty,
   output rsp_type     rsp_data,
   input  logic        rsp_pop
);

   cfg_type cfg_ff;
   logic    mq_push;
   mid_type mq_wdata;
   logic    mq_full;
   logic    mq_pop;
   mid_type mq_rdata;
   logic    mq_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gravity_x        <= '0;
         cfg_ff.gravity_y        <= '0;
         cfg_ff.drag_coefficient <= '0;
         cfg_ff.rest_speed_sq    <= REST_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_GRAVITY_X: cfg_ff.gravity_x        <= csr_wdata;
            CSR_GRAVITY_Y: cfg_ff.gravity_y        <= csr_wdata;
            CSR_DRAG:      cfg_ff.drag_coefficient <= csr_wdata[30:0];
            CSR_REST:      cfg_ff.rest_speed_sq    <= csr_wdata[30:0];
            default: begin
            end
         endcase
      end
   end

   rbmi_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_push  (req_push),
      .in_data  (req_data),
      .in_full  (req_full),
      .out_push (mq_push),
      .out_data (mq_wdata),
      .out_full (mq_full)
   );

   rbmi_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mq_push),
      .push_data (mq_wdata),
      .full      (mq_full),
      .pop       (mq_pop),
      .pop_data  (mq_rdata),
      .empty     (mq_empty)
   );

   rbmi_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_empty  (mq_empty),
      .in_data   (mq_rdata),
      .in_pop    (mq_pop),
      .out_empty (rsp_empty),
      .out_data  (rsp_data),
      .out_pop   (rsp_pop)
   );

endmodule

### rtl/rbmi_checker.sv
// ----------------------------------------------------------------------------
// rbmi_checker
// Port-level checks of the integrator's queue channels.
// ----------------------------------------------------------------------------
module rbmi_checker import rbmi_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_full,
   input logic    rsp_empty,
   input rsp_type rsp_data,
   input logic    rsp_pop
);

   a_empty_after_reset: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_ready_after_reset: assert property (@(posedge clock) reset |=> !req_full)
      else $error("input full right after reset");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty)
      else $error("waiting result dropped");

   a_result_stable: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> $stable(rsp_data))
      else $error("waiting result changed");

endmodule

bind rigid_body_motion_integrator_2d_top rbmi_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_data  (rsp_data),
   .rsp_pop   (rsp_pop)
);

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 2D rigid body motion integrator. A short table
// of directed bodies (rest and move cases, threshold edges, saturation) runs
// first, then random bodies under six register settings. Each body is
// predicted in Q16.16 arithmetic at transfer time, and every popped result is
// compared field by field in order. Push and pop idle at random.
// ----------------------------------------------------------------------------
module tb;
   import rbmi_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int ITEMS_PER_SETTING = 100;

   typedef struct {
      req_type body;
      bit      typed;
      rsp_type result;
   } step_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_GRAVITY_X;
   logic [31:0] csr_wdata = '0;
   logic        req_push = 1'b0;
   req_type     req_data = '0;
   logic        req_full;
   logic        rsp_empty;
   rsp_type     rsp_data;
   logic        rsp_pop = 1'b0;

   longint      grav_x = 0;
   longint      grav_y = 0;
   longint      drag_k = 0;
   longint      rest_sq = 655;
   int          push_idle = 0;
   int          pop_idle = 0;
   int          errors = 0;
   int          bodies_sent = 0;
   int          results_seen = 0;
   int          moved_count = 0;
   rsp_type     pending_bodies[$];
   step_row_type directed[$];

   rigid_body_motion_integrator_2d_top uut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_push(req_push), .req_data(req_data), .req_full(req_full),
      .rsp_empty(rsp_empty), .rsp_data(rsp_data), .rsp_pop(rsp_pop)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("DONE: errors detected");
      $finish;
   end

   function automatic longint clamp32(input longint x);
      longint res;
      res = x;
      if (x > 64'sd2147483647) res = 64'sd2147483647;
      if (x < -64'sd2147483648) res = -64'sd2147483648;
      return res;
   endfunction

   function automatic rsp_type integrate_body(input req_type b);
      rsp_type o;
      longint px, py, vx, vy, fx, fy, m, dt, ax, ay, dvx, dvy, npx, npy, nvx, nvy;
      longint unsigned mag_x, mag_y, speed;
      px = $signed(b.pos_x);
      py = $signed(b.pos_y);
      vx = $signed(b.vel_x);
      vy = $signed(b.vel_y);
      m  = longint'(b.mass);
      dt = longint'(b.step_time);
      fx = clamp32($signed(b.force_x) + grav_x - ((vx * drag_k) >>> 16));
      fy = clamp32($signed(b.force_y) + grav_y - ((vy * drag_k) >>> 16));
      mag_x = (vx < 0) ? -vx : vx;
      mag_y = (vy < 0) ? -vy : vy;
      speed = (mag_x * mag_x + mag_y * mag_y) >> 16;
      npx = px;
      npy = py;
      nvx = 0;
      nvy = 0;
      if (speed > longint'(rest_sq) || fx != 0 || fy != 0) begin
         ax  = clamp32((fx * 65536) / m);
         ay  = clamp32((fy * 65536) / m);
         dvx = clamp32((ax * dt) >>> 16);
         dvy = clamp32((ay * dt) >>> 16);
         npx = clamp32(px + ((dvx * dt) >>> 17) + ((vx * dt) >>> 16));
         npy = clamp32(py + ((dvy * dt) >>> 17) + ((vy * dt) >>> 16));
         nvx = clamp32(vx + dvx);
         nvy = clamp32(vy + dvy);
      end
      o.tag_out   = b.body_tag;
      o.new_pos_x = npx[31:0];
      o.new_pos_y = npy[31:0];
      o.new_vel_x = nvx[31:0];
      o.new_vel_y = nvy[31:0];
      o.moved     = (npx != px) || (npy != py);
      return o;
   endfunction

   function automatic req_type make_body(input logic [15:0] tag, input logic [31:0] px,
                                         input logic [31:0] py, input logic [31:0] vx,
                                         input logic [31:0] vy, input logic [31:0] fx,
                                         input logic [31:0] fy, input logic [30:0] m,
                                         input logic [30:0] dt);
      req_type b;
      b.body_tag = tag;
      b.pos_x = px;
      b.pos_y = py;
      b.vel_x = vx;
      b.vel_y = vy;
      b.force_x = fx;
      b.force_y = fy;
      b.mass = m;
      b.step_time = dt;
      return b;
   endfunction

   function automatic rsp_type make_result(input req_type b);
      rsp_type o;
      o.tag_out = b.body_tag;
      o.new_pos_x = b.pos_x;
      o.new_pos_y = b.pos_y;
      o.new_vel_x = '0;
      o.new_vel_y = '0;
      o.moved = 1'b0;
      return o;
   endfunction

   task automatic add_row(input req_type b, input bit typed);
      step_row_type row;
      row.body = b;
      row.typed = typed;
      row.result = make_result(b);
      directed.push_back(row);
   endtask

   function automatic logic [31:0] pick_word();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(5))
         0: return r;
         1: return 32'h7FFFFFFF;
         2: return 32'h80000000;
         3: return '0;
         default: return {{12{r[19]}}, r[19:0]};
      endcase
   endfunction

   function automatic req_type random_body();
      req_type b;
      logic [31:0] r;
      b.body_tag = $urandom;
      b.pos_x = pick_word();
      b.pos_y = pick_word();
      b.vel_x = pick_word();
      b.vel_y = pick_word();
      b.force_x = pick_word();
      b.force_y = pick_word();
      b.mass = ($urandom_range(3) != 0) ? 31'($urandom_range(1024, 262144))
                                        : 31'($urandom_range(1, 32'h7FFFFFFF));
      b.step_time = ($urandom_range(4) != 0) ? 31'($urandom_range(0, 131072))
                                             : 31'($urandom);
      if ($urandom_range(3) == 0) begin
         r = $urandom;
         b.vel_x = {{19{r[12]}}, r[12:0]};
         r = $urandom;
         b.vel_y = {{19{r[12]}}, r[12:0]};
         b.force_x = '0;
         b.force_y = '0;
      end
      return b;
   endfunction

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_GRAVITY_X: grav_x = $signed(value);
         CSR_GRAVITY_Y: grav_y = $signed(value);
         CSR_DRAG:      drag_k = longint'(value[30:0]);
         CSR_REST:      rest_sq = longint'(value[30:0]);
         default: ;
      endcase
   endtask

   task automatic drain();
      while (pending_bodies.size() != 0) @(posedge clock);
      repeat (70) @(posedge clock);
   endtask

   task automatic send_body(input req_type b, input bit typed, input rsp_type want);
      while ($urandom_range(99) < push_idle) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= b;
      do @(posedge clock); while (req_full);
      pending_bodies.push_back(typed ? want : integrate_body(b));
      bodies_sent++;
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            results_seen++;
            if (rsp_data.moved) moved_count++;
            if (pending_bodies.size() == 0) begin
               report("unexpected result", rsp_data.tag_out, 0);
            end else begin
               rsp_type want;
               want = pending_bodies.pop_front();
               if (rsp_data.tag_out !== want.tag_out)
                  report("tag_out", rsp_data.tag_out, want.tag_out);
               if (rsp_data.new_pos_x !== want.new_pos_x)
                  report("new_pos_x", rsp_data.new_pos_x, want.new_pos_x);
               if (rsp_data.new_pos_y !== want.new_pos_y)
                  report("new_pos_y", rsp_data.new_pos_y, want.new_pos_y);
               if (rsp_data.new_vel_x !== want.new_vel_x)
                  report("new_vel_x", rsp_data.new_vel_x, want.new_vel_x);
               if (rsp_data.new_vel_y !== want.new_vel_y)
                  report("new_vel_y", rsp_data.new_vel_y, want.new_vel_y);
               if (rsp_data.moved !== want.moved)
                  report("moved", rsp_data.moved, want.moved);
            end
         end
         rsp_pop <= ($urandom_range(99) >= pop_idle);
      end
   end

   initial begin
      logic [31:0] setting[6][4];
      rsp_type     none;
      none = '0;
      setting[0] = '{32'd0, 32'd0, 32'd0, 32'd655};
      setting[1] = '{32'd0, -32'sd642253, 32'd6554, 32'd655};
      setting[2] = '{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF};
      setting[3] = '{32'h80000000, 32'h7FFFFFFF, 32'd0, 32'd0};
      setting[4] = '{{{12{1'b0}}, 20'($urandom)}, -32'sd100000, 32'($urandom_range(0, 70000)),
                     32'($urandom_range(0, 32'h7FFFFFFF))};
      setting[5] = '{32'd0, 32'd0, 32'd0, 32'd65536};

      add_row(make_body(16'h0000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 31'd65536,
                        31'd65536), 1);
      add_row(make_body(16'hFFFF, 32'h7FFFFFFF, 32'h80000000, 32'd10, -32'sd10, 32'd0, 32'd0,
                        31'd1, 31'h7FFFFFFF), 1);
      add_row(make_body(16'h1234, 32'd5, 32'd7, 32'd6553, 32'd0, 32'd0, 32'd0, 31'd65536,
                        31'd65536), 1);
      add_row(make_body(16'h1235, 32'd5, 32'd7, 32'd6557, 32'd0, 32'd0, 32'd0, 31'd65536,
                        31'd65536), 0);
      add_row(make_body(16'h0001, 32'd0, 32'd0, 32'd0, 32'd0, 32'd65536, -32'sd65536,
                        31'd65536, 31'd65536), 0);
      add_row(make_body(16'h0002, 32'd100, 32'd200, 32'd65536, 32'd65536, 32'd0, 32'd0,
                        31'd65536, 31'd0), 0);
      add_row(make_body(16'h0003, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                        32'h7FFFFFFF, 32'h7FFFFFFF, 31'd1, 31'h7FFFFFFF), 0);
      add_row(make_body(16'h0004, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                        32'h80000000, 32'h80000000, 31'd1, 31'h7FFFFFFF), 0);
      add_row(make_body(16'h0005, 32'd0, 32'd0, 32'h80000000, 32'h7FFFFFFF, 32'd1, 32'd0,
                        31'h7FFFFFFF, 31'd65536), 0);
      add_row(make_body(16'h0006, -32'sd65536, 32'd65536, -32'sd3, 32'd3, -32'sd1, 32'd1,
                        31'd1, 31'd1), 0);
      add_row(make_body(16'h0007, 32'd0, 32'd0, 32'd1000000, -32'sd1000000, 32'd0, 32'd0,
                        31'd32768, 31'd6554), 0);
      add_row(make_body(16'h0008, 32'd1, 32'd1, 32'd0, 32'd0, 32'h7FFFFFFF, 32'h80000000,
                        31'h7FFFFFFF, 31'h7FFFFFFF), 0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      push_idle = 37;
      pop_idle = 73;
      foreach (directed[i]) send_body(directed[i].body, directed[i].typed, directed[i].result);
      req_push <= 1'b0;

      for (int s = 0; s < 6; s++) begin
         push_idle = (s < 2) ? 37 : (s < 4) ? 73 : 0;
         pop_idle  = (s < 2) ? 73 : (s < 4) ? 37 : 0;
         drain();
         write_reg(CSR_GRAVITY_X, setting[s][0]);
         write_reg(CSR_GRAVITY_Y, setting[s][1]);
         write_reg(CSR_DRAG, setting[s][2]);
         write_reg(CSR_REST, setting[s][3]);
         csr_we <= 1'b0;
         repeat (ITEMS_PER_SETTING) send_body(random_body(), 0, none);
         req_push <= 1'b0;
      end

      drain();
      $display("covered %0d bodies (%0d moved) over six register settings", bodies_sent,
               moved_count);
      $display("results checked: %0d, mismatches: %0d", results_seen, errors);
      if (errors == 0 && pending_bodies.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/rbmi_pkg.sv
rtl/rbmi_front.sv
rtl/rbmi_queue.sv
rtl/rbmi_back.sv
rtl/rigid_body_motion_integrator_2d_top.sv
rtl/rbmi_checker.sv
verif/tb.sv
